// ===== rtl/tsq_pkg.sv =====
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types, register map and constants of the touch stylus qualifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsq_pkg;

   localparam int TIME_BITS_DEF = 16;

   // register map, word index = paddr[3:2]
   localparam int          CSR_ADDR_W = 4;
   localparam logic [1:0]  REG_WINDOW = 2'd0;
   localparam logic [1:0]  REG_X_OFF  = 2'd1;
   localparam logic [1:0]  REG_Y_OFF  = 2'd2;

   localparam logic [15:0] WINDOW_RST = 16'd45;
   localparam logic [11:0] X_OFF_RST  = 12'h113;
   localparam logic [11:0] Y_OFF_RST  = 12'h0E0;

   // pressure saturates here when the divisor plate reads zero
   localparam logic [14:0] PRESSURE_SAT = 15'd16383;

   // divide by 14 and by 19: q = (n * M) >> 20, exact for n < 4096
   localparam int          RECIP_SHIFT = 20;
   localparam logic [16:0] RECIP_X     = 17'd74899;
   localparam logic [15:0] RECIP_Y     = 16'd55189;

   // radix-2 divider: 14-bit dividend, 12-bit divisor
   localparam int DIV_STEPS = 14;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int REQ_W = 72;
   localparam int RSP_W = 72;

   typedef struct packed {
      logic [15:0] window;
      logic [11:0] x_off;
      logic [11:0] y_off;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic step;
      logic commit;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

// ===== rtl/tsq_csr.sv =====
// ----------------------------------------------------------------------------
// tsq_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsq_csr import tsq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_WINDOW: cfg_in.window = csr_pwdata[15:0];
            REG_X_OFF:  cfg_in.x_off  = csr_pwdata[11:0];
            REG_Y_OFF:  cfg_in.y_off  = csr_pwdata[11:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window <= WINDOW_RST;
         cfg_ff.x_off  <= X_OFF_RST;
         cfg_ff.y_off  <= Y_OFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_WINDOW: csr_prdata = {16'd0, cfg_ff.window};
         REG_X_OFF:  csr_prdata = {20'd0, cfg_ff.x_off};
         REG_Y_OFF:  csr_prdata = {20'd0, cfg_ff.y_off};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsq_ctrl
// Sequencer: accept, multiply, divider steps, commit into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsq_ctrl import tsq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait here while the previous result is still not taken
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/tsq_datapath.sv =====
// ----------------------------------------------------------------------------
// tsq_datapath
// Sample capture, products, radix-2 pressure divider, pen state and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsq_datapath import tsq_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  cfg_type          cfg,
   input  cmd_type          cmd,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int CMP_W = (TIME_BITS + 1 > 16) ? TIME_BITS + 1 : 16;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // captured sample
   logic        touch_ff;
   logic [11:0] rx_ff, ry_ff, z1_ff, z2_ff;
   logic [7:0]  px_ff, py_ff;

   // products
   logic        cx_neg_ff, cy_neg_ff;
   logic [28:0] cx_prod_ff;
   logic [27:0] cy_prod_ff;

   // divider
   logic [11:0] rem_ff, rem_in;
   logic [13:0] quo_ff, quo_in;

   // pen state
   logic                 held_ff, held_in;
   logic [TIME_BITS-1:0] press_ff, press_in, release_ff, release_in;
   logic [7:0]           last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [8:0]           spd_x_ff, spd_x_in, spd_y_ff, spd_y_in;
   logic [9:0]           cal_x_ff, cal_x_in;
   logic [8:0]           cal_y_ff, cal_y_in;

   logic [RSP_W-1:0] rsp_ff, rsp_in;

   logic [12:0] dx, dy, mag_x, mag_y;
   logic [19:0] zprod;
   logic [12:0] shift;
   logic        ge;
   logic        new_press, released, dbl;
   logic [CMP_W-1:0] tsum;
   logic [14:0] pressure;
   logic [9:0]  qx;
   logic [8:0]  qy;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         touch_ff <= req_tdata[0];
         rx_ff    <= req_tdata[12:1];
         ry_ff    <= req_tdata[24:13];
         px_ff    <= req_tdata[32:25];
         py_ff    <= req_tdata[40:33];
         z1_ff    <= req_tdata[52:41];
         z2_ff    <= req_tdata[64:53];
      end
   end

   // calibration: signed difference, magnitude times reciprocal
   assign dx    = {1'b0, rx_ff} - {1'b0, cfg.x_off};
   assign dy    = {1'b0, ry_ff} - {1'b0, cfg.y_off};
   assign mag_x = dx[12] ? (13'd0 - dx) : dx;
   assign mag_y = dy[12] ? (13'd0 - dy) : dy;
   assign zprod = px_ff * z2_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         cx_neg_ff  <= dx[12];
         cy_neg_ff  <= dy[12];
         cx_prod_ff <= mag_x[11:0] * RECIP_X;
         cy_prod_ff <= mag_y[11:0] * RECIP_Y;
      end
   end

   // restoring divider, one quotient bit per step
   assign shift = {rem_ff, quo_ff[13]};
   assign ge    = (shift >= {1'b0, z1_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.mul) begin
         rem_in = '0;
         quo_in = zprod[19:6];
      end else if (cmd.step) begin
         rem_in = ge ? 12'(shift - {1'b0, z1_ff}) : shift[11:0];
         quo_in = {quo_ff[12:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // result and state update
   assign new_press = touch_ff & ~held_ff;
   assign released  = ~touch_ff & held_ff;
   assign tsum      = CMP_W'(press_ff) + CMP_W'(release_ff);
   assign dbl       = new_press & (tsum < CMP_W'(cfg.window));
   assign pressure  = (z1_ff == 12'd0) ? PRESSURE_SAT
                                       : ({1'b0, quo_ff} - 15'(px_ff[7:6]));
   assign qx = cx_prod_ff[RECIP_SHIFT +: 9] == 9'd0 ? 10'd0
                                                    : {1'b0, cx_prod_ff[RECIP_SHIFT +: 9]};
   assign qy = {1'b0, cy_prod_ff[RECIP_SHIFT +: 8]};

   always_comb begin
      held_in    = held_ff;
      press_in   = press_ff;
      release_in = release_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      spd_x_in   = spd_x_ff;
      spd_y_in   = spd_y_ff;
      cal_x_in   = cal_x_ff;
      cal_y_in   = cal_y_ff;
      rsp_in     = rsp_ff;
      if (cmd.commit) begin
         held_in = touch_ff;
         if (touch_ff) begin
            if (new_press) begin
               press_in = TIME_BITS'(1);
               spd_x_in = '0;
               spd_y_in = '0;
            end else begin
               press_in = (press_ff == TIME_MAX) ? TIME_MAX : press_ff + 1'b1;
               spd_x_in = {1'b0, px_ff} - {1'b0, last_x_ff};
               spd_y_in = {1'b0, py_ff} - {1'b0, last_y_ff};
            end
            cal_x_in  = cx_neg_ff ? (10'd0 - qx) : qx;
            cal_y_in  = cy_neg_ff ? (9'd0 - qy) : qy;
            last_x_in = px_ff;
            last_y_in = py_ff;
         end else begin
            if (released) begin
               release_in = TIME_BITS'(1);
            end else begin
               release_in = (release_ff == TIME_MAX) ? TIME_MAX : release_ff + 1'b1;
            end
         end
         rsp_in = {spd_y_in, spd_x_in, last_y_in, last_x_in, cal_y_in, cal_x_in,
                   pressure, dbl, released, new_press, touch_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= 1'b0;
         press_ff   <= '0;
         release_ff <= '0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         spd_x_ff   <= '0;
         spd_y_ff   <= '0;
         cal_x_ff   <= '0;
         cal_y_ff   <= '0;
      end else begin
         held_ff    <= held_in;
         press_ff   <= press_in;
         release_ff <= release_in;
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         spd_x_ff   <= spd_x_in;
         spd_y_ff   <= spd_y_in;
         cal_x_ff   <= cal_x_in;
         cal_y_ff   <= cal_y_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tdata = rsp_ff;

endmodule

// ===== rtl/touch_stylus_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// touch_stylus_qualifier_core
// Pen event, double tap, pressure and calibrated position from touch samples.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  contents
//   req_*     in         tvalid/tready              one touch-panel sample
//   rsp_*     out        tvalid/tready              flags, pressure, position
//   csr_*     in/out     psel/penable, pready=1     tap window, raw offsets
//
// An item passes through accept, a multiply step, 14 steps of the
// radix-2 pressure divider and one commit into the output register.
// The next sample is accepted right after commit, while the result waits.
// A stalled result port holds the block in its commit state.
// Reset is synchronous; it clears pen state and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_stylus_qualifier_core import tsq_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pen_touching, raw_x, raw_y, pixel_x, pixel_y, plate_z1, plate_z2, zero pad
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // is_held, new_press, just_released, double_tap, pressure, calib_x,
   // calib_y, pos_x, pos_y, vel_x, vel_y
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   cmd_type cmd;

   tsq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   tsq_datapath #(
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cfg       (cfg),
      .cmd       (cmd),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== bench/tb_touch_stylus_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// tb_touch_stylus_qualifier_core
// Self-checking bench for the touch stylus qualifier core.
// ----------------------------------------------------------------------------
// Touch samples go in on the req stream and qualified results come back on the
// rsp stream. Every accepted sample runs through a local model of the pen
// logic, and every result transfer is compared field by field with the oldest
// prediction. A short table of directed samples comes first. Pen strokes with
// random content follow under several register settings, among them the
// extremes and a long stroke that runs the press and release counters into
// saturation. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_touch_stylus_qualifier_core;
   import tsq_pkg::*;

   // narrow counters so that saturation is reached within a few hundred samples
   localparam int TIME_W       = 8;
   localparam int X_DIV        = 14;
   localparam int Y_DIV        = 19;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int PRINT_LIMIT  = 40;
   localparam int DIR_N        = 14;
   localparam int LONG_RUN     = 256;
   localparam logic [1:0] REG_SPARE = 2'd3;

   // last field in the lowest bits
   typedef struct packed {
      logic [11:0] plate_z2;
      logic [11:0] plate_z1;
      logic [7:0]  pixel_y;
      logic [7:0]  pixel_x;
      logic [11:0] raw_y;
      logic [11:0] raw_x;
      logic        pen_touching;
   } sample_t;

   typedef struct packed {
      logic signed [8:0]  vel_y;
      logic signed [8:0]  vel_x;
      logic [7:0]         pos_y;
      logic [7:0]         pos_x;
      logic signed [8:0]  calib_y;
      logic signed [9:0]  calib_x;
      logic signed [14:0] pressure;
      logic               double_tap, just_released, new_press, is_held;
   } qual_result_t;

   // directed row; flags = {held, press, release, tap}, used where typed is set
   typedef struct packed {
      logic        touch;
      logic [11:0] rx, ry;
      logic [7:0]  px, py;
      logic [11:0] z1, z2;
      logic        typed;
      logic [3:0]  flags;
      logic [14:0] pres;
   } dir_row_t;

   dir_row_t directed_rows [DIR_N] = '{
      // idle after reset, zero divisor
      '{1'b0, 12'd0,    12'd0,    8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 4'b0000, 15'd16383},
      // new press right after reset is a double tap, full-scale inputs
      '{1'b1, 12'd4095, 12'd4095, 8'd255, 8'd255, 12'd1,    12'd4095, 1'b1, 4'b1101, 15'd16313},
      '{1'b1, 12'd0,    12'd0,    8'd0,   8'd0,   12'd4095, 12'd0,    1'b1, 4'b1000, 15'd0},
      // most negative pressure
      '{1'b1, 12'd275,  12'd224,  8'd255, 8'd191, 12'd1,    12'd0,    1'b1, 4'b1000, 15'h7FFD},
      '{1'b0, 12'd4095, 12'd4095, 8'd128, 8'd100, 12'd4095, 12'd4095, 1'b1, 4'b0010, 15'd0},
      '{1'b1, 12'hAAA,  12'h555,  8'hAA,  8'h55,  12'h555,  12'hAAA,  1'b0, 4'b0000, 15'd0},
      '{1'b1, 12'h555,  12'hAAA,  8'h55,  8'hAA,  12'hAAA,  12'h555,  1'b0, 4'b0000, 15'd0},
      '{1'b0, 12'd0,    12'd0,    8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 4'b0010, 15'd16383},
      '{1'b0, 12'h800,  12'h400,  8'h80,  8'h40,  12'h800,  12'hFFF,  1'b0, 4'b0000, 15'd0},
      '{1'b1, 12'h7FF,  12'h3FF,  8'h7F,  8'hBF,  12'hFFF,  12'hFFF,  1'b0, 4'b0000, 15'd0},
      '{1'b1, 12'h001,  12'h002,  8'h01,  8'hC0,  12'h002,  12'h001,  1'b0, 4'b0000, 15'd0},
      // one below the offsets: quotient truncates to zero
      '{1'b1, 12'd274,  12'd223,  8'hFE,  8'hFF,  12'h7FF,  12'h800,  1'b0, 4'b0000, 15'd0},
      '{1'b1, 12'd261,  12'd205,  8'h3F,  8'h40,  12'h0FF,  12'h100,  1'b0, 4'b0000, 15'd0},
      '{1'b0, 12'd0,    12'd4095, 8'd255, 8'd0,   12'd1,    12'd4095, 1'b0, 4'b0000, 15'd0}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // model state and register copies
   logic [15:0]       tap_window = WINDOW_RST;
   logic [11:0]       x_offset   = X_OFF_RST;
   logic [11:0]       y_offset   = Y_OFF_RST;
   logic              pen_held   = 1'b0;
   logic [TIME_W-1:0] press_len  = '0;
   logic [TIME_W-1:0] lift_len   = '0;
   logic [7:0]        last_px    = '0;
   logic [7:0]        last_py    = '0;
   logic signed [8:0] speed_xq   = '0;
   logic signed [8:0] speed_yq   = '0;
   logic signed [9:0] cal_xq     = '0;
   logic signed [8:0] cal_yq     = '0;

   qual_result_t expected_events [$];

   bit src_gaps    = 1'b0;
   bit sink_stalls = 1'b0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int n_errors = 0, n_results = 0, n_sent = 0, n_settings = 0;
   int n_presses = 0, n_releases = 0, n_taps = 0;

   touch_stylus_qualifier_core #(.TIME_BITS(TIME_W)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [TIME_W-1:0] sat_step(logic [TIME_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic qual_result_t qualify_sample(sample_t s);
      qual_result_t r;
      int unsigned  prod;
      int           pres;
      logic         press_edge, lift_edge;
      prod = 32'(s.pixel_x) * 32'(s.plate_z2);
      if (s.plate_z1 == '0) begin
         r.pressure = PRESSURE_SAT;
      end else begin
         pres = int'((prod >> 6) / 32'(s.plate_z1)) - int'(s.pixel_x >> 6);
         r.pressure = 15'(pres);
      end
      press_edge = s.pen_touching && !pen_held;
      lift_edge  = !s.pen_touching && pen_held;
      // sum taken before the counters move on
      r.double_tap = press_edge && (int'(press_len) + int'(lift_len) < int'(tap_window));
      pen_held = s.pen_touching;
      if (press_edge) press_len = '0;
      if (s.pen_touching) press_len = sat_step(press_len);
      if (lift_edge) lift_len = '0;
      if (!s.pen_touching) lift_len = sat_step(lift_len);
      if (s.pen_touching) begin
         cal_xq = 10'((int'(s.raw_x) - int'(x_offset)) / X_DIV);
         cal_yq = 9'((int'(s.raw_y) - int'(y_offset)) / Y_DIV);
         if (press_edge) begin
            speed_xq = '0;
            speed_yq = '0;
         end else begin
            speed_xq = 9'(int'(s.pixel_x) - int'(last_px));
            speed_yq = 9'(int'(s.pixel_y) - int'(last_py));
         end
         last_px = s.pixel_x;
         last_py = s.pixel_y;
      end
      r.is_held       = s.pen_touching;
      r.new_press     = press_edge;
      r.just_released = lift_edge;
      r.calib_x       = cal_xq;
      r.calib_y       = cal_yq;
      r.pos_x         = last_px;
      r.pos_y         = last_py;
      r.vel_x         = speed_xq;
      r.vel_y         = speed_yq;
      return r;
   endfunction

   // ---------------------------------------------------------------- random

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned skewed(int unsigned maxv);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return maxv;
      return $urandom_range(0, maxv);
   endfunction

   function automatic sample_t rand_sample(logic touch);
      sample_t s;
      s.pen_touching = touch;
      s.raw_x        = 12'(skewed(4095));
      s.raw_y        = 12'(skewed(4095));
      s.pixel_x      = 8'(skewed(255));
      s.pixel_y      = 8'(skewed(255));
      s.plate_z1     = ($urandom_range(0, 11) == 0) ? 12'd0 : 12'(skewed(4095));
      s.plate_z2     = 12'(skewed(4095));
      return s;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      if (n_errors < PRINT_LIMIT)
         $display("[cycle %0d] result %0d: %s", cycle_count, n_results, msg);
      n_errors++;
   endtask

   task automatic cmp_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      qual_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = qual_result_t'(rsp_tdata);
         if (expected_events.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding");
         end else begin
            want = expected_events.pop_front();
            cmp_field("is_held", got.is_held, want.is_held);
            cmp_field("new_press", got.new_press, want.new_press);
            cmp_field("just_released", got.just_released, want.just_released);
            cmp_field("double_tap", got.double_tap, want.double_tap);
            cmp_field("pressure", got.pressure, want.pressure);
            cmp_field("calib_x", got.calib_x, want.calib_x);
            cmp_field("calib_y", got.calib_y, want.calib_y);
            cmp_field("pos_x", got.pos_x, want.pos_x);
            cmp_field("pos_y", got.pos_y, want.pos_y);
            cmp_field("vel_x", got.vel_x, want.vel_x);
            cmp_field("vel_y", got.vel_y, want.vel_y);
            n_presses  += want.new_press;
            n_releases += want.just_released;
            n_taps     += want.double_tap;
         end
         n_results++;
      end
   end

   // result sink with random back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (sink_stalls && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_events.size());
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_sample(sample_t s, bit typed = 1'b0, logic [3:0] flags = '0,
                              logic [14:0] pres = '0);
      qual_result_t want;
      int unsigned  gap;
      gap = src_gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(s);
      do @(posedge clock); while (!req_tready);
      want = qualify_sample(s);
      if (typed) begin
         {want.is_held, want.new_press, want.just_released, want.double_tap} = flags;
         want.pressure = pres;
      end
      expected_events.push_back(want);
      n_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_WINDOW: tap_window = val[15:0];
         REG_X_OFF:  x_offset   = val[11:0];
         REG_Y_OFF:  y_offset   = val[11:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // junk in the unused upper bits, plus a write to the unmapped slot
   task automatic set_config(logic [15:0] win, logic [11:0] xo, logic [11:0] yo);
      drain();
      csr_write(REG_WINDOW, {16'($urandom), win});
      csr_write(REG_X_OFF, {20'($urandom), xo});
      csr_write(REG_Y_OFF, {20'($urandom), yo});
      csr_write(REG_SPARE, $urandom);
      n_settings++;
   endtask

   // alternating held and lifted runs; an occasional run of random contact
   task automatic run_strokes(int n);
      int          left;
      int unsigned r, run;
      bit          touch_now, noisy;
      left      = n;
      touch_now = 1'b0;
      while (left > 0) begin
         r     = $urandom_range(0, 9);
         noisy = (r == 9);
         if (r < 6) run = $urandom_range(1, 6);
         else if (r < 9) run = $urandom_range(7, 40);
         else run = $urandom_range(2, 12);
         touch_now = !touch_now;
         for (int k = 0; k < run && left > 0; k++) begin
            send_sample(rand_sample(noisy ? 1'($urandom) : touch_now));
            left--;
         end
      end
   endtask

   // both counters pinned at their maximum before the next press
   task automatic run_long_stroke();
      for (int k = 0; k < LONG_RUN; k++) send_sample(rand_sample(1'b1));
      for (int k = 0; k < LONG_RUN; k++) send_sample(rand_sample(1'b0));
      send_sample(rand_sample(1'b1));
      send_sample(rand_sample(1'b0));
   endtask

   initial begin
      dir_row_t row;
      sample_t  s;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_gaps = 1'b1;
      sink_stalls <= 1'b1;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         s.pen_touching = row.touch;
         s.raw_x        = row.rx;
         s.raw_y        = row.ry;
         s.pixel_x      = row.px;
         s.pixel_y      = row.py;
         s.plate_z1     = row.z1;
         s.plate_z2     = row.z2;
         send_sample(s, row.typed, row.flags, row.pres);
      end

      set_config(16'd8, 12'd0, 12'd0);
      src_gaps = 1'b0;
      sink_stalls <= 1'b0;
      run_strokes(80);

      set_config(16'd0, 12'd4095, 12'd4095);
      src_gaps = 1'b1;
      sink_stalls <= 1'b1;
      run_strokes(80);

      set_config(16'hFFFF, 12'($urandom), 12'($urandom));
      run_strokes(80);

      // saturated sum is 510, equal to the window: no tap
      set_config(16'd510, X_OFF_RST, Y_OFF_RST);
      run_long_stroke();

      set_config(16'($urandom_range(1, 100)), 12'($urandom), 12'($urandom));
      run_strokes(80);

      set_config(WINDOW_RST, X_OFF_RST, Y_OFF_RST);
      run_strokes(50);

      drain();
      if (expected_events.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_events.size()));

      $display("%0d samples sent, %0d results checked over %0d register settings",
               n_sent, n_results, n_settings + 1);
      $display("%0d presses, %0d releases, %0d double taps, %0d mismatches",
               n_presses, n_releases, n_taps, n_errors);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tsq_pkg.sv
rtl/tsq_csr.sv
rtl/tsq_ctrl.sv
rtl/tsq_datapath.sv
rtl/touch_stylus_qualifier_core.sv
bench/tb_touch_stylus_qualifier_core.sv
